// ===== rtl/core/polynomial_evaluator_core_defines.svh =====
`ifndef POLYNOMIAL_EVALUATOR_CORE_DEFINES_SVH
`define POLYNOMIAL_EVALUATOR_CORE_DEFINES_SVH

// concurrent check on the core clock, quiet while reset is high
`define POLYEV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// a signal keeps its value in the cycle after a condition
`define POLYEV_ASSERT_HOLD(label, cond, sig, msg) \
   `POLYEV_ASSERT(label, (cond) |=> $stable(sig), msg)

`endif

// ===== rtl/core/polyev_pkg.sv =====
package polyev_pkg;

   localparam int X_W         = 16;
   localparam int COEF_W      = 16;
   localparam int ACC_W       = 32;
   localparam int FRAC_W      = 8;
   localparam int DEG_W       = 3;
   localparam int COEF_SLOTS  = 7;
   localparam int MAX_TERMS_DEF = 7;
   localparam int PROD_W      = ACC_W + X_W;
   localparam int SUM_W       = PROD_W - FRAC_W + 1;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_IDX_W   = 3;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef coef_type [COEF_SLOTS-1:0] coef_bank_type;
   typedef logic signed [ACC_W-1:0] acc_type;
   typedef logic signed [X_W-1:0] sample_type;

   typedef struct packed {
      logic valid;
      logic clip;
   } stage_ctl_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEGREE    = 3'd0,
      CSR_COEF_POW0 = 3'd1,
      CSR_COEF_POW1 = 3'd2,
      CSR_COEF_POW2 = 3'd3,
      CSR_COEF_POW3 = 3'd4,
      CSR_COEF_POW4 = 3'd5,
      CSR_COEF_POW5 = 3'd6,
      CSR_COEF_POW6 = 3'd7
   } csr_index_type;

   // coefficient in Q8.8 widened to the Q16.16 accumulator
   function automatic acc_type coef_to_acc(coef_type c);
      return {{(ACC_W-COEF_W-FRAC_W){c[COEF_W-1]}}, c, {FRAC_W{1'b0}}};
   endfunction

endpackage

// ===== rtl/core/polynomial_evaluator_core.sv =====
// an accepted word runs through the entry stage and both stages of every Horner step
//   before its result word appears, whatever the configured degree
// throughput: one word per cycle; a stalled result freezes the whole pipeline
// each Horner step is a multiply stage and a shift/add/clip stage
// reset: synchronous, active high; clears all valid bits and the register file,
//   the data stages are not reset and only carry meaning beside a set valid bit
module polynomial_evaluator_core #(
   parameter int MAX_TERMS = polyev_pkg::MAX_TERMS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // sample in
   input  logic                               req_valid,
   output logic                               req_stall,
   input  polyev_pkg::sample_type             req_x_value,
   // result out
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output polyev_pkg::acc_type                rsp_poly_value,
   output logic                               rsp_saturated,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [polyev_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [polyev_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [polyev_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                               pready
);
   import polyev_pkg::*;

   // one Horner step per coefficient below the top one
   localparam int STEPS = MAX_TERMS - 1;
   localparam logic [DEG_W-1:0] DEG_MAX = DEG_W'(STEPS);

   logic [DEG_W-1:0] csr_degree;
   coef_bank_type    csr_coefs;
   logic [DEG_W-1:0] deg_eff;
   logic             pipe_en;
   logic             accept;

   // entry stage: accumulator seeded with the top coefficient
   stage_ctl_type    s0_ctl_ff;
   acc_type          s0_acc_ff;
   sample_type       s0_x_ff;
   stage_ctl_type    s0_ctl_in;

   // chain between steps, slot 0 is the entry stage
   stage_ctl_type    ctl_chain [STEPS+1];
   acc_type          acc_chain [STEPS+1];
   sample_type       x_chain   [STEPS+1];

   polyev_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .degree  (csr_degree),
      .coefs   (csr_coefs)
   );

   // a degree beyond the unrolled steps is clamped to the top step
   assign deg_eff = (csr_degree > DEG_MAX) ? DEG_MAX : csr_degree;

   // whole pipeline moves unless a finished word is held at the output
   assign pipe_en   = !(rsp_valid && rsp_stall);
   assign req_stall = !pipe_en;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s0_ctl_in.valid = accept;
      s0_ctl_in.clip  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ctl_ff <= '0;
      end else if (pipe_en) begin
         s0_ctl_ff <= s0_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s0_acc_ff <= coef_to_acc(csr_coefs[deg_eff]);
         s0_x_ff   <= req_x_value;
      end
   end

   assign ctl_chain[0] = s0_ctl_ff;
   assign acc_chain[0] = s0_acc_ff;
   assign x_chain[0]   = s0_x_ff;

   // step i folds in coefficient STEPS-1-i, and only when it lies below the degree;
   // lower degrees pass through the upper steps untouched
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic [DEG_W-1:0] COEF_IDX = DEG_W'(STEPS - 1 - i);

      polyev_step u_step (
         .clock   (clock),
         .reset   (reset),
         .en      (pipe_en),
         .active  (COEF_IDX < deg_eff),
         .coef    (csr_coefs[COEF_IDX]),
         .ctl_in  (ctl_chain[i]),
         .acc_in  (acc_chain[i]),
         .x_in    (x_chain[i]),
         .ctl_out (ctl_chain[i+1]),
         .acc_out (acc_chain[i+1]),
         .x_out   (x_chain[i+1])
      );
   end

   // last step's registers double as the output register
   assign rsp_valid      = ctl_chain[STEPS].valid;
   assign rsp_saturated  = ctl_chain[STEPS].clip;
   assign rsp_poly_value = acc_chain[STEPS];

   `POLYEV_ASSERT(a_accept_enters, accept |=> s0_ctl_ff.valid, "accepted word missing from entry stage")
   `POLYEV_ASSERT(a_entry_no_clip, s0_ctl_ff.valid |-> !s0_ctl_ff.clip, "entry stage carries a clip flag")
   `POLYEV_ASSERT_HOLD(a_frozen_entry_acc, !pipe_en, s0_acc_ff, "entry accumulator moved while frozen")
   `POLYEV_ASSERT_HOLD(a_frozen_entry_ctl, !pipe_en, s0_ctl_ff, "entry control moved while frozen")

endmodule

// ===== rtl/core/polyev_csr.sv =====
module polyev_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [polyev_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [polyev_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [polyev_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                  pready,
   output logic [polyev_pkg::DEG_W-1:0]          degree,
   output polyev_pkg::coef_bank_type             coefs
);
   import polyev_pkg::*;

   logic [DEG_W-1:0]     degree_ff;
   coef_bank_type        coef_ff;
   logic                 wr_en;
   logic [CSR_IDX_W-1:0] idx;
   logic [CSR_IDX_W-1:0] slot;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = paddr[CSR_ADDR_W-1:2];
   assign slot   = idx - CSR_IDX_W'(CSR_COEF_POW0);

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= '0;
         coef_ff   <= '0;
      end else if (wr_en) begin
         case (idx) inside
            CSR_DEGREE: begin
               degree_ff <= pwdata[DEG_W-1:0];
            end
            [CSR_COEF_POW0:CSR_COEF_POW6]: begin
               coef_ff[slot] <= pwdata[COEF_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (idx) inside
         CSR_DEGREE: begin
            prdata = CSR_DATA_W'(degree_ff);
         end
         [CSR_COEF_POW0:CSR_COEF_POW6]: begin
            prdata = CSR_DATA_W'($unsigned(coef_ff[slot]));
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign degree = degree_ff;
   assign coefs  = coef_ff;

endmodule

// ===== rtl/core/polyev_step.sv =====
`include "polynomial_evaluator_core_defines.svh"

module polyev_step (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       active,
   input  polyev_pkg::coef_type       coef,
   input  polyev_pkg::stage_ctl_type  ctl_in,
   input  polyev_pkg::acc_type        acc_in,
   input  polyev_pkg::sample_type     x_in,
   output polyev_pkg::stage_ctl_type  ctl_out,
   output polyev_pkg::acc_type        acc_out,
   output polyev_pkg::sample_type     x_out
);
   import polyev_pkg::*;

   // multiply half
   stage_ctl_type             ctl_a_ff;
   acc_type                   acc_a_ff;
   sample_type                x_a_ff;
   logic signed [PROD_W-1:0]  prod_a_ff;

   // shift, add and clip half
   stage_ctl_type             ctl_b_ff;
   acc_type                   acc_b_ff;
   sample_type                x_b_ff;
   acc_type                   acc_b_in;
   logic                      clip_b_in;
   logic signed [SUM_W-1:0]   sum;
   logic                      ovf;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
      end else if (en) begin
         ctl_a_ff       <= ctl_in;
         ctl_b_ff.valid <= ctl_a_ff.valid;
         ctl_b_ff.clip  <= clip_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_a_ff  <= acc_in;
         x_a_ff    <= x_in;
         prod_a_ff <= acc_in * x_in;
         acc_b_ff  <= acc_b_in;
         x_b_ff    <= x_a_ff;
      end
   end

   // floor of product / 256 plus coefficient in Q16.16, exact in SUM_W bits
   assign sum = $signed({prod_a_ff[PROD_W-1], prod_a_ff[PROD_W-1:FRAC_W]})
              + SUM_W'(coef_to_acc(coef));
   assign ovf = (sum[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){1'b0}})
             && (sum[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){1'b1}});

   always_comb begin
      acc_b_in  = acc_a_ff;
      clip_b_in = ctl_a_ff.clip;
      if (active) begin
         clip_b_in = ctl_a_ff.clip | ovf;
         if (ovf) begin
            acc_b_in = sum[SUM_W-1] ? ACC_MIN : ACC_MAX;
         end else begin
            acc_b_in = sum[ACC_W-1:0];
         end
      end
   end

   assign ctl_out = ctl_b_ff;
   assign acc_out = acc_b_ff;
   assign x_out   = x_b_ff;

   `POLYEV_ASSERT(a_skip_passes_acc, en && ctl_a_ff.valid && !active |=> acc_b_ff == $past(acc_a_ff), "idle step changed the accumulator")
   `POLYEV_ASSERT(a_skip_keeps_clip, en && ctl_a_ff.valid && !active |=> ctl_b_ff.clip == $past(ctl_a_ff.clip), "idle step changed the clip flag")
   `POLYEV_ASSERT(a_new_clip_is_rail, en && ctl_a_ff.valid && active && !ctl_a_ff.clip |=> !ctl_b_ff.clip || acc_b_ff == ACC_MAX || acc_b_ff == ACC_MIN, "clip flagged without a rail value")

endmodule

// ===== tb/sv/polynomial_evaluator_core_tb.sv =====
`timescale 1ns / 100ps

module polynomial_evaluator_core_tb;
   import polyev_pkg::*;

   // delay of one word in flight through the pipeline, whatever the degree
   localparam int PIPE_LATENCY = 1 + 2 * (MAX_TERMS_DEF - 1);
   localparam int CYCLE_LIMIT  = 800000;
   localparam int TOP_POWER    = MAX_TERMS_DEF - 1;
   localparam int PHASE_COUNT  = 12;
   localparam int PHASE_WORDS  = 98;
   localparam longint SUM_HI   = 64'sd2147483647;
   localparam longint SUM_LO   = -64'sd2147483648;

   typedef struct {
      acc_type value;
      logic    saturated;
   } horner_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // sample side
   logic       req_valid   = 1'b0;
   logic       req_stall;
   sample_type req_x_value = '0;

   // result side
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   acc_type rsp_poly_value;
   logic    rsp_saturated;

   // register port
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // shadow copy of the registers, updated as each write lands
   logic [DEG_W-1:0] degree_mirror = '0;
   coef_bank_type    coef_mirror   = '0;

   // predicted results, oldest first
   horner_result_type expected_poly_q[$];
   int mismatch_count = 0;

   // receiver idling control; hold_request is picked up by the stall process
   bit idle_quiet   = 1'b0;
   int hold_request = 0;
   int hold_left    = 0;
   int stall_left   = 0;
   int stall_roll;

   polynomial_evaluator_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_x_value    (req_x_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_poly_value (rsp_poly_value),
      .rsp_saturated  (rsp_saturated),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // horner evaluation from the shadow registers, highest power first
   function automatic horner_result_type horner_eval(input sample_type x);
      horner_result_type res;
      int top;
      longint acc;
      longint sum;
      // degree 7 folds back onto the top coefficient
      top = (degree_mirror > TOP_POWER) ? TOP_POWER : int'(degree_mirror);
      acc = longint'(coef_mirror[top]) * 256;
      res.saturated = 1'b0;
      for (int k = top; k > 0; k--) begin
         // arithmetic shift of the wide product gives floor rounding
         sum = ((acc * longint'(x)) >>> FRAC_W) + longint'(coef_mirror[k-1]) * 256;
         if (sum > SUM_HI) begin
            sum = SUM_HI;
            res.saturated = 1'b1;
         end else if (sum < SUM_LO) begin
            sum = SUM_LO;
            res.saturated = 1'b1;
         end
         acc = sum;
      end
      res.value = acc_type'(acc);
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // sender gap: mostly none, some short, a few long
   function automatic int sender_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (idle_quiet) return 0;
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic sample_type random_x();
      int roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0, 1, 2, 3: return sample_type'($urandom());
         4, 5, 6:    return sample_type'($urandom_range(0, 1023) - 512);
         7:          return sample_type'($urandom_range(0, 127) - 64);
         default: begin
            case ($urandom_range(0, 4))
               0:       return 16'sh8000;
               1:       return 16'sh7fff;
               2:       return 16'sh0000;
               3:       return 16'sh0001;
               default: return 16'shffff;
            endcase
         end
      endcase
   endfunction

   // tame picks keep the value in range at higher degrees
   function automatic coef_type random_coef(input bit tame);
      int roll;
      roll = $urandom_range(0, 9);
      if (tame) return coef_type'($urandom_range(0, 511) - 256);
      case (roll)
         0, 1, 2, 3: return coef_type'($urandom_range(0, 1023) - 512);
         4, 5, 6:    return coef_type'($urandom());
         7:          return 16'sh7fff;
         8:          return 16'sh8000;
         default:    return coef_type'($urandom_range(0, 15) - 8);
      endcase
   endfunction

   // apb write with a setup and an access phase; the register lands on the access edge,
   // then the port is released and left idle before the task returns
   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         CSR_DEGREE: degree_mirror = data[DEG_W-1:0];
         default:    coef_mirror[int'(idx) - 1] = data[COEF_W-1:0];
      endcase
      @(posedge clock);
   endtask

   // wait for the pipeline to empty, then rewrite every register;
   // upper data bits are random so that only the field width may stick
   task automatic load_polynomial(input logic [DEG_W-1:0] deg, input coef_bank_type bank);
      logic [CSR_DATA_W-1:0] data;
      req_valid <= 1'b0;
      while (expected_poly_q.size() != 0) @(posedge clock);
      data = $urandom();
      data[DEG_W-1:0] = deg;
      write_register(CSR_DEGREE, data);
      for (int i = 0; i < COEF_SLOTS; i++) begin
         data = $urandom();
         data[COEF_W-1:0] = bank[i];
         write_register(csr_index_type'(int'(CSR_COEF_POW0) + i), data);
      end
   endtask

   // offer one word, wait for it to be taken, log its prediction
   task automatic send_sample(input sample_type x);
      int gap;
      req_valid   <= 1'b1;
      req_x_value <= x;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_poly_q.push_back(horner_eval(x));
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // degree zero returns the widened constant term and never clips
   task automatic test_degree_zero();
      coef_bank_type bank;
      for (int i = 0; i < COEF_SLOTS; i++) bank[i] = random_coef(1'b0);
      bank[0] = 16'sh7fff;
      load_polynomial(3'd0, bank);
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      bank[0] = 16'sh8000;
      load_polynomial(3'd0, bank);
      send_sample(16'sh0000);
      send_sample(16'sh0001);
   endtask

   // full-scale coefficients and samples drive the later stages into the rails; a zero sample is sent as well
   task automatic test_saturation();
      coef_bank_type bank;
      for (int i = 0; i < COEF_SLOTS; i++) bank[i] = 16'sh7fff;
      load_polynomial(3'd6, bank);
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      for (int i = 0; i < COEF_SLOTS; i++) bank[i] = 16'sh8000;
      load_polynomial(3'd6, bank);
      send_sample(16'sh7fff);
   endtask

   // a degree of seven behaves as six: only x^6 is set here
   task automatic test_degree_clamp();
      coef_bank_type bank;
      bank = '0;
      bank[6] = 16'sh0100;
      load_polynomial(3'd7, bank);
      send_sample(16'sh0200);
      send_sample(-16'sh0200);
      send_sample(16'sh0100);
   endtask

   // second stage sees fractional products, which the shift rounds down
   task automatic test_floor_rounding();
      coef_bank_type bank;
      bank = '0;
      bank[2] = 16'sh0001;
      load_polynomial(3'd2, bank);
      send_sample(-16'sh0001);
      send_sample(16'sh0001);
      send_sample(-16'sh0003);
      send_sample(16'sh0003);
      send_sample(-16'sh00ff);
   endtask

   // receiver holds off long enough for the pipeline to fill and push back
   task automatic test_backpressure();
      coef_bank_type bank;
      for (int i = 0; i < COEF_SLOTS; i++) bank[i] = random_coef(1'b1);
      load_polynomial(3'd6, bank);
      idle_quiet   = 1'b1;
      hold_request = 300;
      for (int n = 0; n < 60; n++) send_sample(random_x());
      idle_quiet = 1'b0;
   endtask

   // phases walk every degree first, then random settings; one phase
   // runs with no idling on either side
   task automatic test_random_phases();
      coef_bank_type bank;
      logic [DEG_W-1:0] deg;
      bit tame;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         deg  = (p < 8) ? p[DEG_W-1:0] : DEG_W'($urandom_range(0, 7));
         tame = (p % 3 == 0);
         for (int i = 0; i < COEF_SLOTS; i++) bank[i] = random_coef(tame);
         load_polynomial(deg, bank);
         idle_quiet = (p == 5);
         for (int n = 0; n < PHASE_WORDS; n++) send_sample(random_x());
      end
      idle_quiet = 1'b0;
   endtask

   // result checker: each accepted word against the oldest prediction
   always @(posedge clock) begin
      horner_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_poly_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result word %h", rsp_poly_value));
         end else begin
            want = expected_poly_q.pop_front();
            if (rsp_poly_value !== want.value)
               report_mismatch($sformatf("poly_value %h, predicted %h",
                                         rsp_poly_value, want.value));
            if (rsp_saturated !== want.saturated)
               report_mismatch($sformatf("saturated %b, predicted %b",
                                         rsp_saturated, want.saturated));
         end
      end
   end

   // receiver stall: long hold-off on request, else random short and long gaps
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 75) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_left = (stall_roll < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            rsp_stall <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("polynomial_evaluator_core_tb failed");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_degree_zero();
      test_saturation();
      test_degree_clamp();
      test_floor_rounding();
      test_backpressure();
      test_random_phases();
      req_valid <= 1'b0;
      while (expected_poly_q.size() != 0) @(posedge clock);
      // extra cycles catch any stray word after the last one
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (mismatch_count == 0)
         $display("polynomial_evaluator_core_tb passed");
      else
         $display("polynomial_evaluator_core_tb failed");
      $finish;
   end

endmodule
